// ===== rtl/til_pkg.sv =====
package til_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADMODE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [1:0] MODE_NEAREST = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_RSVD2   = 2'd2;
  localparam logic [1:0] MODE_RSVD3   = 2'd3;

  localparam int TIME_W  = 48;
  localparam int SHIFT_W = 32;
  localparam int MAG_W   = SHIFT_W + 1;
  localparam int PROD_W  = MAG_W + TIME_W;
  localparam int NUM_W   = PROD_W + 2;
  localparam int HALF_W  = TIME_W / 2;
  localparam int REM_W   = TIME_W + 2;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  typedef struct packed {
    logic [1:0]                action;
    logic [TIME_W-1:0]         time_value;
    logic signed [SHIFT_W-1:0] shift_value;
  } in_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift_out;
    logic [1:0]                status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_WALK,
    S_FIN,
    S_MUL0,
    S_MUL1,
    S_PREP,
    S_DIV
  } state_t;

endpackage

// ===== rtl/til_ram.sv =====
module til_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/table_interpolation_lookup.sv =====
// Shift-versus-time table with nearest or linear lookup. Start a command
// beat (clear, append, query) when busy is low; exactly one result beat
// follows, shown for one cycle with done high, and it cannot be stalled.
// Clear, append, an empty-table query, an unsupported-mode query between the
// ends and action code 3 answer in the next cycle. A query at or beyond
// either end answers from the edge state. Otherwise the table is walked one
// entry per cycle through the single read port of the table memory: nearest
// mode walks every stored point, then a finish state; linear mode walks to
// the bracketing segment, then (unless it has zero width) the multiply
// states, a setup state and a divider that forms the quotient one bit at a
// time. The next command can start in the cycle its predecessor's result is
// shown. No clearing pass after reset: only entries below the fill count are ever used.
module table_interpolation_lookup #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  til_pkg::in_t  req,
  input  logic          mode_we,
  input  logic [1:0]    mode_data,
  output logic          done,
  output til_pkg::out_t rsp
);
  import til_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = TIME_W + SHIFT_W;

  // control
  state_t          state, state_next;
  logic [1:0]      mode;
  logic [CW-1:0]   count;
  logic [AW-1:0]   idx;
  logic [TIME_W-1:0] first_time, last_time;

  // query working registers
  logic [TIME_W-1:0]         qtime;
  logic [TIME_W-1:0]         best_dist;
  logic signed [SHIFT_W-1:0] best_shift;
  logic [TIME_W-1:0]         prev_time;
  logic signed [SHIFT_W-1:0] prev_shift;
  logic [TIME_W-1:0]         den, num;
  logic [MAG_W-1:0]          mag;
  logic                      neg;
  logic [PROD_W-1:0]         prod;
  logic [NUM_W-1:0]          numer;
  logic [REM_W-1:0]          rem;
  logic [MAG_W-1:0]          quo;
  logic [CNT_W-1:0]          div_cnt;

  // memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic [TIME_W-1:0] rd_time;
  logic signed [SHIFT_W-1:0] rd_shift;

  assign rd_time  = ram_rdata[EW-1:SHIFT_W];
  assign rd_shift = ram_rdata[SHIFT_W-1:0];

  til_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic              accept;
  logic [AW-1:0]     last_idx;
  logic              is_full;
  logic [TIME_W-1:0] app_time;
  logic [TIME_W-1:0] cur_dist;
  logic              bracket;
  logic signed [MAG_W-1:0] seg_diff;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  div2;
  logic signed [SHIFT_W-1:0] lin_res;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign last_idx = AW'(count - CW'(1));
  assign is_full  = (count >= CW'(TABLE_DEPTH));
  // appends never go back in time
  assign app_time = (count != '0 && req.time_value < last_time) ? last_time
                                                                : req.time_value;
  assign cur_dist = (rd_time > qtime) ? rd_time - qtime : qtime - rd_time;
  // first entry at or after the query time closes the bracketing segment
  assign bracket  = (idx != '0) && (qtime <= rd_time);
  assign seg_diff = MAG_W'(rd_shift) - MAG_W'(prev_shift);
  assign div2     = REM_W'({den, 1'b0});
  assign rem_shift = {rem[REM_W-2:0], numer[NUM_W-1]};
  assign lin_res  = neg ? prev_shift - SHIFT_W'(quo) : prev_shift + SHIFT_W'(quo);

  // memory is written only from idle, and its read data is used only in the query
  // path, never from a cycle with a write, so no forwarding is needed
  assign ram_we    = accept && req.action == ACT_APPEND && !is_full;
  assign ram_waddr = AW'(count);
  assign ram_wdata = {app_time, req.shift_value};

  always_comb begin
    state_next = state;
    ram_raddr  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && req.action == ACT_QUERY && count != '0) begin
          if (count == CW'(1) || req.time_value <= first_time) begin
            state_next = S_EDGE;
          end else if (req.time_value >= last_time) begin
            ram_raddr  = last_idx;
            state_next = S_EDGE;
          end else if (mode == MODE_NEAREST || mode == MODE_LINEAR) begin
            state_next = S_WALK;
          end
        end
      end
      S_EDGE: state_next = S_IDLE;
      S_WALK: begin
        ram_raddr = idx + AW'(1);
        if (mode == MODE_NEAREST) begin
          if (idx == last_idx) state_next = S_FIN;
        end else if (bracket) begin
          state_next = (rd_time == prev_time) ? S_FIN : S_MUL0;
        end
      end
      S_FIN:  state_next = S_IDLE;
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_PREP;
      S_PREP: state_next = S_DIV;
      S_DIV:  if (div_cnt == CNT_W'(1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_LINEAR;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (mode_we) mode <= mode_data;
      if (accept) begin
        case (req.action)
          ACT_CLEAR: count <= '0;
          ACT_APPEND: if (!is_full) count <= count + CW'(1);
          default: ;
        endcase
        // a command that needs no table read answers at once
        if (state_next == S_IDLE) done <= 1'b1;
      end
      if (state == S_EDGE || state == S_FIN ||
          (state == S_DIV && div_cnt == CNT_W'(1))) begin
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_time <= app_time;
      if (count == '0) first_time <= app_time;
    end
    unique case (state)
      S_IDLE: begin
        qtime <= req.time_value;
        idx   <= '0;
        rsp.shift_out <= '0;
        rsp.status    <= ST_OK;
        if (accept) begin
          case (req.action)
            ACT_APPEND: if (is_full) rsp.status <= ST_FULL;
            ACT_QUERY: begin
              if (count == '0) begin
                rsp.status <= ST_EMPTY;
              end else if (state_next == S_IDLE) begin
                rsp.status <= ST_BADMODE;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE: rsp.shift_out <= rd_shift;
      S_WALK: begin
        idx <= idx + AW'(1);
        den <= rd_time - prev_time;
        num <= qtime - prev_time;
        neg <= seg_diff < 0;
        mag <= (seg_diff < 0) ? MAG_W'(-seg_diff) : MAG_W'(seg_diff);
        if (mode == MODE_NEAREST) begin
          if (idx == '0 || cur_dist < best_dist) begin
            best_dist  <= cur_dist;
            best_shift <= rd_shift;
          end
        end else if (bracket) begin
          // keep the segment start for the result
          best_shift <= prev_shift;
        end else begin
          prev_time  <= rd_time;
          prev_shift <= rd_shift;
        end
      end
      S_FIN: rsp.shift_out <= best_shift;
      S_MUL0: prod <= PROD_W'(mag * num[HALF_W-1:0]);
      S_MUL1: prod <= prod + (PROD_W'(mag * num[TIME_W-1:HALF_W]) << HALF_W);
      S_PREP: begin
        // round half up: floor((2*prod + den) / (2*den))
        numer   <= NUM_W'({prod, 1'b0}) + NUM_W'(den);
        rem     <= '0;
        quo     <= '0;
        div_cnt <= CNT_W'(NUM_W);
      end
      S_DIV: begin
        numer   <= {numer[NUM_W-2:0], 1'b0};
        div_cnt <= div_cnt - CNT_W'(1);
        if (rem_shift >= div2) begin
          rem <= rem_shift - div2;
          quo <= {quo[MAG_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[MAG_W-2:0], 1'b0};
        end
        if (div_cnt == CNT_W'(1)) begin
          rsp.shift_out <= neg
            ? prev_shift - SHIFT_W'({quo[MAG_W-2:0], rem_shift >= div2})
            : prev_shift + SHIFT_W'({quo[MAG_W-2:0], rem_shift >= div2});
        end
      end
      default: ;
    endcase
    if (state == S_DIV && div_cnt != CNT_W'(1)) begin
      rsp.shift_out <= lin_res;
    end
  end

endmodule

// ===== rtl/til_chk.sv =====
module til_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input til_pkg::in_t  req,
  input logic          done,
  input til_pkg::out_t rsp
);
  import til_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  a_quick_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.action != ACT_QUERY) |=> (done && !busy))
    else $error("non-query beat not answered next cycle");

  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.shift_out == '0))
    else $error("nonzero shift with error status");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a command beat");

endmodule

bind table_interpolation_lookup til_chk u_til_chk (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .req  (req),
  .done (done),
  .rsp  (rsp)
);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import til_pkg::*;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t req = '0;
  logic mode_we = 1'b0;
  logic [1:0] mode_data = MODE_LINEAR;
  logic done;
  out_t rsp;

  table_interpolation_lookup #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .mode_we(mode_we),
    .mode_data(mode_data),
    .done(done),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // shadow copy of the table and the mode register
  logic [TIME_W-1:0] pt_time[DEPTH];
  logic signed [SHIFT_W-1:0] pt_shift[DEPTH];
  int unsigned pt_count = 0;
  logic [1:0] cur_mode = MODE_LINEAR;

  in_t pending_cmds[$];
  out_t expected_results[$];
  int unsigned mismatches = 0;
  bit no_gaps = 1'b0;

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // shift at time q for the current table, linear or nearest lookup
  function automatic out_t shift_at_time(input logic [TIME_W-1:0] q);
    out_t r;
    logic [TIME_W-1:0] best_d, d, den;
    int best;
    logic signed [SHIFT_W:0] diff;
    logic [127:0] mag, numer, quo;
    r.shift_out = '0;
    r.status = ST_OK;
    if (pt_count == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    if (pt_count == 1 || q <= pt_time[0]) begin
      r.shift_out = pt_shift[0];
      return r;
    end
    if (q >= pt_time[pt_count-1]) begin
      r.shift_out = pt_shift[pt_count-1];
      return r;
    end
    if (cur_mode == MODE_NEAREST) begin
      best = 0;
      best_d = (pt_time[0] > q) ? pt_time[0] - q : q - pt_time[0];
      for (int i = 1; i < pt_count; i++) begin
        d = (pt_time[i] > q) ? pt_time[i] - q : q - pt_time[i];
        if (d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      r.shift_out = pt_shift[best];
    end else if (cur_mode == MODE_LINEAR) begin
      for (int i = 0; i + 1 < pt_count; i++) begin
        if (q >= pt_time[i] && q <= pt_time[i+1]) begin
          den = pt_time[i+1] - pt_time[i];
          if (den == 0) begin
            r.shift_out = pt_shift[i];
            return r;
          end
          diff = $signed({pt_shift[i+1][SHIFT_W-1], pt_shift[i+1]}) -
                 $signed({pt_shift[i][SHIFT_W-1], pt_shift[i]});
          mag = diff < 0 ? 128'(-diff) : 128'(diff);
          // round half up: (2*mag*off + den) / (2*den)
          numer = 2 * mag * 128'(q - pt_time[i]) + 128'(den);
          quo = numer / (2 * 128'(den));
          r.shift_out = diff < 0 ? pt_shift[i] - SHIFT_W'(quo) : pt_shift[i] + SHIFT_W'(quo);
          return r;
        end
      end
    end else begin
      r.status = ST_BADMODE;
    end
    return r;
  endfunction

  // apply one accepted command to the shadow table and queue its result
  task automatic predict_cmd(input in_t c);
    out_t r;
    logic [TIME_W-1:0] t;
    r = '0;
    case (action_t'(c.action))
      ACT_CLEAR: begin
        pt_count = 0;
      end
      ACT_APPEND: begin
        if (pt_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          t = c.time_value;
          // late points are clamped up to keep the table sorted
          if (pt_count > 0 && t < pt_time[pt_count-1]) t = pt_time[pt_count-1];
          pt_time[pt_count] = t;
          pt_shift[pt_count] = c.shift_value;
          pt_count++;
        end
      end
      ACT_QUERY: r = shift_at_time(c.time_value);
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  // driver: a beat moves when start is high and busy is low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_cmd(req);
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && (no_gaps || $urandom_range(99) >= 37)) begin
          req <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, check each done cycle
  always @(posedge clk) begin
    out_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result shift %h status %0d", rsp.shift_out, rsp.status));
      end else begin
        e = expected_results.pop_front();
        if (rsp.shift_out !== e.shift_out)
          report($sformatf("shift_out %h, expected %h", rsp.shift_out, e.shift_out));
        if (rsp.status !== e.status)
          report($sformatf("status %0d, expected %0d", rsp.status, e.status));
      end
    end
  end

  function automatic logic [TIME_W-1:0] rnd_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic signed [SHIFT_W-1:0] rnd_shift();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_cmd(input action_t a, input logic [TIME_W-1:0] t,
                          input logic signed [SHIFT_W-1:0] s);
    in_t c;
    c.action = a;
    c.time_value = t;
    c.shift_value = s;
    pending_cmds.push_back(c);
  endtask

  // wait until every command is out and every result is back
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0);
  endtask

  // mode register only changes while the block is idle
  task automatic set_mode(input logic [1:0] m);
    drain();
    mode_we <= 1'b1;
    mode_data <= m;
    @(posedge clk);
    mode_we <= 1'b0;
    cur_mode = m;
  endtask

  // one table lifetime: clear, a mostly sorted run of appends, queries around it
  task automatic random_table(output int unsigned n_items);
    logic [TIME_W-1:0] pts[$];
    logic [TIME_W-1:0] t, q;
    int n_app, n_q, k;
    logic [TIME_W-1:0] step_max;
    n_items = 0;
    n_app = ($urandom_range(7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
    n_q = $urandom_range(3, 12);
    case ($urandom_range(3))
      0: step_max = 48'd4;
      1: step_max = 48'hffff;
      2: step_max = 48'hff_ffff_ffff;
      default: step_max = 48'h0fff_ffff_ffff;
    endcase
    t = ($urandom_range(1)) ? rnd_time() >> $urandom_range(47) : '0;
    push_cmd(ACT_CLEAR, rnd_time(), rnd_shift());
    if ($urandom_range(3) == 0) push_cmd(ACT_QUERY, rnd_time(), rnd_shift());
    for (int i = 0; i < n_app; i++) begin
      // mostly sorted, now and then a late point or a random one
      if ($urandom_range(15) == 0) t = rnd_time();
      else t = t + (rnd_time() % (step_max + 1));
      pts.push_back(t);
      push_cmd(ACT_APPEND, t, rnd_shift());
      if ($urandom_range(5) == 0) push_cmd(ACT_QUERY, rnd_time(), rnd_shift());
    end
    for (int i = 0; i < n_q; i++) begin
      k = $urandom_range(pts.size() - 1);
      case ($urandom_range(7))
        0: q = rnd_time();
        1: q = pts[k];
        2: q = (k + 1 < pts.size()) ? pts[k] + (pts[k+1] - pts[k]) / 2 : pts[k];
        3: q = ($urandom_range(1)) ? '0 : '1;
        default: q = (k + 1 < pts.size() && pts[k+1] > pts[k]) ?
                     pts[k] + rnd_time() % (pts[k+1] - pts[k]) : pts[k] + 1;
      endcase
      push_cmd(ACT_QUERY, q, rnd_shift());
    end
    if ($urandom_range(9) == 0) push_cmd(ACT_NONE, rnd_time(), rnd_shift());
    n_items = pending_cmds.size();
  endtask

  initial begin
    int unsigned total, n;
    logic [1:0] m;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, single point, half-way rounding, clamped append
    set_mode(MODE_LINEAR);
    push_cmd(ACT_QUERY, 48'd5, 32'sd0);
    push_cmd(ACT_APPEND, 48'd0, 32'sd0);
    push_cmd(ACT_QUERY, 48'd7, 32'sd0);
    push_cmd(ACT_APPEND, 48'd2, 32'sd1);
    push_cmd(ACT_APPEND, 48'd4, -32'sd1);
    push_cmd(ACT_QUERY, 48'd1, 32'sd0);
    push_cmd(ACT_QUERY, 48'd3, 32'sd0);
    push_cmd(ACT_APPEND, 48'd1, 32'sd5);
    push_cmd(ACT_APPEND, '1, 32'sh80000000);
    push_cmd(ACT_QUERY, '1, 32'sd0);
    push_cmd(ACT_QUERY, 48'h8000_0000_0000, 32'sd0);
    push_cmd(ACT_QUERY, 48'd0, 32'sd0);
    push_cmd(ACT_NONE, '1, 32'sh7fffffff);
    // nearest: a tie between two points picks the lower index
    set_mode(MODE_NEAREST);
    push_cmd(ACT_QUERY, 48'd3, 32'sd0);
    push_cmd(ACT_QUERY, 48'h7fff_ffff_ffff, 32'sd0);
    // unsupported modes still answer at the ends
    set_mode(MODE_RSVD2);
    push_cmd(ACT_QUERY, 48'd3, 32'sd0);
    push_cmd(ACT_QUERY, 48'd0, 32'sd0);
    set_mode(MODE_RSVD3);
    push_cmd(ACT_QUERY, 48'd1, 32'sd0);
    push_cmd(ACT_CLEAR, 48'd0, 32'sd0);
    push_cmd(ACT_QUERY, 48'd1, 32'sd0);

    total = 0;
    while (total < 900) begin
      case ($urandom_range(9))
        0: m = MODE_RSVD2;
        1: m = MODE_RSVD3;
        2, 3, 4, 5: m = MODE_NEAREST;
        default: m = MODE_LINEAR;
      endcase
      set_mode(m);
      // one stretch with back-to-back starts
      no_gaps = (total >= 300 && total < 450);
      random_table(n);
      total += n;
    end
    set_mode(MODE_LINEAR);
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule
